/* rtl/tlveh_pkg.sv */
// Package: shared types, constants and the VarNumber encoding function for the TLV encoder.
package tlveh_pkg;

	// Request kinds; the fourth code is unused and produces no bytes
	typedef enum logic [1:0] {
		REQ_HEADER  = 2'd0,
		REQ_NONNEG  = 2'd1,
		REQ_PAYLOAD = 2'd2
	} req_kind_t;

	localparam int unsigned MaxBytes  = 14;
	localparam int unsigned BufWidth  = 8 * MaxBytes;
	localparam int unsigned CountBits = 4;

	localparam logic [31:0] VarOneLimit = 32'd253;
	localparam logic [31:0] VarMax16    = 32'h0000_ffff;
	localparam logic [7:0]  VarMark16   = 8'd253;
	localparam logic [7:0]  VarMark32   = 8'd254;

	// One classified request: bytes left aligned in wire order, plus byte count
	typedef struct packed {
		logic [BufWidth-1:0]  data;
		logic [CountBits-1:0] count;
	} desc_t;

	// One VarNumber: up to five bytes left aligned, and its length
	typedef struct packed {
		logic [39:0] bytes;
		logic [2:0]  len;
	} varnum_t;

	function automatic varnum_t enc_varnum(input logic [31:0] v);
		varnum_t r;
		if (v < VarOneLimit) begin
			r.bytes = {v[7:0], 32'd0};
			r.len   = 3'd1;
		end else if (v <= VarMax16) begin
			r.bytes = {VarMark16, v[15:0], 16'd0};
			r.len   = 3'd3;
		end else begin
			r.bytes = {VarMark32, v};
			r.len   = 3'd5;
		end
		return r;
	endfunction

endpackage

/* rtl/tlveh_if.sv */
// Interfaces: request channel and encoded byte channel with valid/ready handshake.
interface tlveh_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] tlv_type;
	logic [31:0] length_value;
	logic [31:0] number_value;
	logic [7:0]  data_byte;

	modport source (output valid, req_type, tlv_type, length_value, number_value, data_byte,
		input ready);
	modport sink (input valid, req_type, tlv_type, length_value, number_value, data_byte,
		output ready);
endinterface

interface tlveh_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

/* rtl/tlveh_front.sv */
// Front end: accepts requests, encodes them into a byte descriptor, hands it to the queue.
module tlveh_front (
	input  logic                clk,
	input  logic                arst_n,
	tlveh_req_if.sink           req,
	output tlveh_pkg::desc_t    push_desc,
	output logic                push_valid,
	input  logic                push_ready
);

	tlveh_pkg::varnum_t type_vn;
	tlveh_pkg::varnum_t len_vn;
	tlveh_pkg::desc_t   desc_c;
	logic [31:0]        val_bytes;
	logic [2:0]         val_len;
	logic [3:0]         hdr_len;
	logic               kind_ok;
	logic               in_xfer;
	tlveh_pkg::desc_t   desc_s1;
	logic               valid_s1;

	assign req.ready = !valid_s1 || push_ready;
	assign in_xfer   = req.valid && req.ready;

	// Value bytes of a non-negative integer, shortest of 1, 2 or 4
	always_comb begin
		if (req.number_value <= 32'h0000_00ff) begin
			val_bytes = {req.number_value[7:0], 24'd0};
			val_len   = 3'd1;
		end else if (req.number_value <= tlveh_pkg::VarMax16) begin
			val_bytes = {req.number_value[15:0], 16'd0};
			val_len   = 3'd2;
		end else begin
			val_bytes = req.number_value;
			val_len   = 3'd4;
		end
	end

	// Classify and pack the request bytes in wire order
	always_comb begin
		type_vn = tlveh_pkg::enc_varnum(req.tlv_type);
		len_vn  = tlveh_pkg::enc_varnum(req.length_value);
		hdr_len = 4'(type_vn.len) + 4'd1;
		desc_c  = '0;
		kind_ok = 1'b1;
		unique case (req.req_type)
			tlveh_pkg::REQ_HEADER: begin
				desc_c.data  = {type_vn.bytes, 72'd0}
					| ({len_vn.bytes, 72'd0} >> {type_vn.len, 3'b000});
				desc_c.count = 4'(type_vn.len) + 4'(len_vn.len);
			end
			tlveh_pkg::REQ_NONNEG: begin
				desc_c.data  = {type_vn.bytes, 72'd0}
					| ({5'd0, val_len, 104'd0} >> {type_vn.len, 3'b000})
					| ({val_bytes, 80'd0} >> {hdr_len, 3'b000});
				desc_c.count = hdr_len + 4'(val_len);
			end
			tlveh_pkg::REQ_PAYLOAD: begin
				desc_c.data  = {req.data_byte, 104'd0};
				desc_c.count = 4'd1;
			end
			default: begin
				kind_ok = 1'b0;
			end
		endcase
	end

	// Stage register: holds one descriptor until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= kind_ok;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			desc_s1 <= desc_c;
		end
	end

	assign push_desc  = desc_s1;
	assign push_valid = valid_s1;

endmodule

/* rtl/tlveh_queue.sv */
// Descriptor queue: small register FIFO between front end and back end.
module tlveh_queue #(
	parameter int unsigned Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tlveh_pkg::desc_t wr_desc,
	input  logic             wr_valid,
	output logic             wr_ready,
	output tlveh_pkg::desc_t rd_desc,
	output logic             rd_valid,
	input  logic             rd_pop
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	tlveh_pkg::desc_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign wr_ready = cnt_q != CntW'(Depth);
	assign rd_valid = cnt_q != '0;
	assign do_push  = wr_valid && wr_ready;
	assign do_pop   = rd_pop && rd_valid;
	assign rd_desc  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

/* rtl/tlveh_back.sv */
// Back end: serialises descriptors one byte per cycle into the output register while rsp.ready allows.
module tlveh_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tlveh_pkg::desc_t q_desc,
	input  logic             q_valid,
	output logic             q_pop,
	tlveh_rsp_if.source      rsp
);

	logic [tlveh_pkg::BufWidth-1:0]  cur_data_q;
	logic [tlveh_pkg::CountBits-1:0] cur_left_q;
	logic                            out_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            out_last_q;
	logic                            advance;
	logic                            cur_busy;

	assign advance  = !out_valid_q || rsp.ready;
	assign cur_busy = cur_left_q != '0;
	// Load the next descriptor when idle or as the current one sends its final byte
	assign q_pop    = q_valid && (!cur_busy || (advance && cur_left_q == 4'd1));

	// Current descriptor: shift out the top byte on each advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_left_q <= '0;
		end else if (q_pop) begin
			cur_left_q <= q_desc.count;
		end else if (advance && cur_busy) begin
			cur_left_q <= cur_left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_data_q <= q_desc.data;
		end else if (advance && cur_busy) begin
			cur_data_q <= {cur_data_q[tlveh_pkg::BufWidth-9:0], 8'd0};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cur_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cur_busy) begin
			out_byte_q <= cur_data_q[tlveh_pkg::BufWidth-1 -: 8];
			out_last_q <= cur_left_q == 4'd1;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.last     = out_last_q;

endmodule

/* rtl/tlv_element_header_encoder_top.sv */
// Top level: TLV element and header encoder, one encoded byte per output transfer.
// A request passes the stage register, the queue, the serialiser and the output register in turn.
// One output byte per cycle while the output is ready; a request encodes to 1 to 10 bytes,
// and the next request's bytes follow with no gap when its descriptor is already queued.
// The front end takes a new request every cycle until the descriptor queue is full.
// Reset: arst_n clears all valid flags, queue pointers and counts; data registers are not reset.
module tlv_element_header_encoder_top #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	tlveh_req_if.sink   req,
	tlveh_rsp_if.source rsp
);

	tlveh_pkg::desc_t push_desc;
	logic             push_valid;
	logic             push_ready;
	tlveh_pkg::desc_t q_desc;
	logic             q_valid;
	logic             q_pop;

	tlveh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_desc  (push_desc),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	tlveh_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_desc  (push_desc),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.rd_desc  (q_desc),
		.rd_valid (q_valid),
		.rd_pop   (q_pop)
	);

	tlveh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_desc  (q_desc),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

/* rtl/tlveh_checker.sv */
// Checker: port-level assertions for the TLV encoder, bound to the top level.
module tlveh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last
);

	// Nothing is offered on the output while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// Stalled output keeps its byte and flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("stalled output changed");

	// Bytes of one request leave back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a request");

	// Input ready only drops right after an input transfer filled the stage
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input ready dropped without a transfer");

endmodule

bind tlv_element_header_encoder_top tlveh_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_byte  (rsp.out_byte),
	.last      (rsp.last)
);
